@@ sv/bmorph_pkg.sv @@
// shared types and constants of the 3x3 binary morphology block
package bmorph_pkg;

  // default image limits
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // field and register widths
  localparam int unsigned FW_W   = 12;
  localparam int unsigned FH_W   = 13;
  localparam int unsigned MASK_W = 9;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // pixel code: bit 0 nonzero, bit 1 full foreground
  localparam int unsigned CODE_W = 2;
  // line store entry: {middle code, upper code}
  localparam int unsigned LINE_W = 2 * CODE_W;
  // window column: {lower, middle, upper} codes, three columns
  localparam int unsigned COL_W  = 3 * CODE_W;
  localparam int unsigned WIN_W  = 3 * COL_W;

  localparam logic [PIX_W-1:0]  PIX_FG  = 8'd255;
  localparam logic [CODE_W-1:0] CODE_FG = 2'b11;

  // register reset values
  localparam logic [FW_W-1:0]   FW_RST   = 12'd640;
  localparam logic [FH_W-1:0]   FH_RST   = 13'd480;
  localparam logic [MASK_W-1:0] MASK_RST = 9'h1FF;

  typedef enum logic {
    MODE_DILATE = 1'b0,
    MODE_ERODE  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MORPH_MODE   = 2'd2,
    REG_KERNEL_MASK  = 2'd3
  } reg_idx_e;

  // per-item info handed from the position control to the window stage
  typedef struct packed {
    logic              fwd;     // line entry was rewritten at the read edge
    logic              col0;    // input column is zero
    logic              emit;    // item produces an output pixel
    logic              last;    // output pixel closes the frame
    logic [2:0]        col_in;  // center column ox+1-c is interior, per tap column c
    logic [2:0]        row_in;  // center row oy+1-r is interior, per tap row r
    logic [CODE_W-1:0] code;    // code of the incoming pixel
  } item_t;

endpackage

@@ sv/bmorph_line_ram.sv @@
// line store memory: two rows of pixel codes, one entry per column
module bmorph_line_ram #(
  parameter int unsigned DEPTH = bmorph_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              clr_en_i,
  input  logic [$clog2(DEPTH)-1:0]          clr_addr_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr_i,
  input  logic [bmorph_pkg::LINE_W-1:0]     wr_data_i,
  input  logic                              rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr_i,
  output logic [bmorph_pkg::LINE_W-1:0]     rd_data_o
);

  logic [bmorph_pkg::LINE_W-1:0] mem [DEPTH];
  logic [bmorph_pkg::LINE_W-1:0] rd_data_q;

  // single write port, clear sweep has priority
  always_ff @(posedge clk_i) begin
    if (clr_en_i) begin
      mem[clr_addr_i] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

`ifndef NO_ASSERTIONS
  // the clear sweep never meets a line update
  assert property (@(posedge clk_i) clr_en_i |-> !wr_en_i)
    else $error("line update during clear sweep");
`endif

endmodule

@@ sv/bmorph_ctrl.sv @@
// position control: raster counters, line store addressing and the read stage
module bmorph_ctrl #(
  parameter int unsigned MAX_WIDTH  = bmorph_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bmorph_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [bmorph_pkg::PIX_W-1:0]      pixel_value_i,
  input  logic [$clog2(MAX_WIDTH):0]        width_i,
  input  logic [$clog2(MAX_HEIGHT):0]       height_i,
  input  logic                              stage_ready_i,
  output logic                              rd_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr_o,
  output logic                              clr_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      clr_addr_o,
  output logic                              s1_valid_o,
  output bmorph_pkg::item_t                 s1_item_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      s1_addr_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] in_col_q, in_col_d;
  logic [1:0]    in_row_q, in_row_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [RW-1:0] out_row_q, out_row_d;
  logic          clr_q, clr_d;
  logic [CW-1:0] clr_addr_q, clr_addr_d;
  logic          s1_valid_q, s1_valid_d;
  bmorph_pkg::item_t s1_item_q, item;
  logic [CW-1:0] s1_addr_q;

  logic accept, s1_fire, in_wrap, out_wrap, row_end, emit, last, col0;
  logic [CW:0] col_inc, ox_inc, ox_ext, wm1, wm2;
  logic [RW:0] oy_inc, oy_ext, hm1, hm2;
  logic [bmorph_pkg::PIX_W-1:0] pix;

  // handshake of the read stage
  assign s1_fire    = s1_valid_q && stage_ready_i;
  assign in_ready_o = !clr_q && (!s1_valid_q || stage_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // position compares
  assign col0    = (in_col_q == '0);
  assign col_inc = (CW+1)'(in_col_q) + (CW+1)'(1);
  assign ox_ext  = (CW+1)'(out_col_q);
  assign ox_inc  = ox_ext + (CW+1)'(1);
  assign oy_ext  = (RW+1)'(out_row_q);
  assign oy_inc  = oy_ext + (RW+1)'(1);
  assign wm1     = width_i - (CW+1)'(1);
  assign wm2     = width_i - (CW+1)'(2);
  assign hm1     = height_i - (RW+1)'(1);
  assign hm2     = height_i - (RW+1)'(2);
  assign in_wrap  = (col_inc >= width_i);
  assign out_wrap = (ox_inc >= width_i);
  assign row_end  = (oy_inc >= height_i);
  assign emit     = (in_row_q == 2'd2) || ((in_row_q == 2'd1) && !col0);
  assign last     = emit && out_wrap && row_end;

  // pixel code and item info
  assign pix = opcode_i ? '0 : pixel_value_i;

  always_comb begin
    item.fwd       = s1_fire && (s1_addr_q == in_col_q);
    item.col0      = col0;
    item.emit      = emit;
    item.last      = last;
    item.col_in[0] = (ox_inc <= wm2);
    item.col_in[1] = (out_col_q != '0) && (ox_ext <= wm2);
    item.col_in[2] = (out_col_q >= CW'(2)) && (ox_ext <= wm1);
    item.row_in[0] = (oy_inc <= hm2);
    item.row_in[1] = (out_row_q != '0) && (oy_ext <= hm2);
    item.row_in[2] = (out_row_q >= RW'(2)) && (oy_ext <= hm1);
    item.code      = {pix == bmorph_pkg::PIX_FG, pix != '0};
  end

  // raster counters advance on input transfers, the output counters only on emitting ones
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (accept) begin
      if (last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        if (in_wrap) begin
          in_col_d = '0;
          in_row_d = (in_row_q == 2'd2) ? 2'd2 : in_row_q + 2'd1;
        end else begin
          in_col_d = in_col_q + CW'(1);
        end
        if (emit) begin
          if (out_wrap) begin
            out_col_d = '0;
            out_row_d = out_row_q + RW'(1);
          end else begin
            out_col_d = out_col_q + CW'(1);
          end
        end
      end
    end
  end

  // clear sweep after reset and read stage occupancy
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + CW'(1);
      if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
        clr_d = 1'b0;
      end
    end
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item;
      s1_addr_q <= in_col_q;
    end
  end

  assign rd_en_o    = accept;
  assign rd_addr_o  = in_col_q;
  assign clr_en_o   = clr_q;
  assign clr_addr_o = clr_addr_q;
  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_item_q;
  assign s1_addr_o  = s1_addr_q;

`ifndef NO_ASSERTIONS
  // a stalled read stage keeps its item and address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !stage_ready_i |=> s1_valid_q && $stable(s1_addr_q))
    else $error("read stage item lost during stall");

  // output counters stay at the origin until the first output row starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_row_q == 2'd0) |-> (out_col_q == '0) && (out_row_q == '0))
    else $error("output position moved before first emit");

  // frame end returns every counter to the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> (in_col_q == '0) && (in_row_q == 2'd0) && (out_col_q == '0))
    else $error("counters not cleared at frame end");
`endif

endmodule

@@ sv/bmorph_win.sv @@
// window stage: line store update, 3x3 window, dilation and erosion, result register
module bmorph_win (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s1_valid_i,
  input  bmorph_pkg::item_t                 item_i,
  input  logic [bmorph_pkg::LINE_W-1:0]     rd_data_i,
  input  logic                              morph_mode_i,
  input  logic [bmorph_pkg::MASK_W-1:0]     kernel_mask_i,
  output logic                              stage_ready_o,
  output logic                              wr_en_o,
  output logic [bmorph_pkg::LINE_W-1:0]     wr_data_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_foreground_o,
  output logic                              end_of_frame_o
);

  localparam int unsigned CODE_W = bmorph_pkg::CODE_W;
  localparam int unsigned COL_W  = bmorph_pkg::COL_W;
  localparam int unsigned WIN_W  = bmorph_pkg::WIN_W;

  logic [WIN_W-1:0]              win_q, win_d, win_shift, win_next, eval_win;
  logic [bmorph_pkg::LINE_W-1:0] last_wr_q, line;
  logic [COL_W-1:0]              newcol;
  logic                          fire, fg;
  logic                          out_valid_q, out_valid_d;
  logic                          out_fg_q, out_eof_q;

  assign stage_ready_o = !out_valid_q || out_ready_i;
  assign fire          = s1_valid_i && stage_ready_o;

  // line entry, taken from the previous write when it raced the read
  assign line   = item_i.fwd ? last_wr_q : rd_data_i;
  assign newcol = {item_i.code, line};

  // upper row takes the old middle, middle row takes the new pixel
  assign wr_en_o   = fire;
  assign wr_data_o = {item_i.code, line[2*CODE_W-1:CODE_W]};

  // window shift; a row start evaluates the previous row's last window
  assign win_shift = {{COL_W{1'b0}}, win_q[WIN_W-1:COL_W]} | {newcol, {(2*COL_W){1'b0}}};

  always_comb begin
    if (item_i.col0) begin
      eval_win = {{COL_W{1'b0}}, win_q[WIN_W-1:COL_W]};
      win_next = {newcol, {(2*COL_W){1'b0}}};
    end else begin
      eval_win = win_shift;
      win_next = win_shift;
    end
  end

  // tap evaluation over the nine mask bits
  always_comb begin
    logic dil;
    logic ero;
    logic [CODE_W-1:0] refl;
    logic [CODE_W-1:0] tap;
    dil = 1'b0;
    ero = item_i.col_in[1] && item_i.row_in[1] &&
          (eval_win[COL_W + CODE_W +: CODE_W] == bmorph_pkg::CODE_FG);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        refl = eval_win[(2-c)*COL_W + (2-r)*CODE_W +: CODE_W];
        tap  = eval_win[c*COL_W + r*CODE_W +: CODE_W];
        if (kernel_mask_i[r*3+c] && item_i.col_in[c] && item_i.row_in[r] &&
            (refl == bmorph_pkg::CODE_FG)) begin
          dil = 1'b1;
        end
        if (kernel_mask_i[r*3+c] && !tap[0]) begin
          ero = 1'b0;
        end
      end
    end
    fg = (morph_mode_i == bmorph_pkg::MODE_ERODE) ? ero : dil;
  end

  // window register and result register occupancy
  always_comb begin
    win_d = win_q;
    if (fire) begin
      win_d = item_i.last ? '0 : win_next;
    end
    out_valid_d = out_valid_q;
    if (fire && item_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload and last line write
  always_ff @(posedge clk_i) begin
    if (fire) begin
      last_wr_q <= wr_data_o;
    end
    if (fire && item_i.emit) begin
      out_fg_q  <= fg;
      out_eof_q <= item_i.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_foreground_o = out_fg_q;
  assign end_of_frame_o   = out_eof_q;

`ifndef NO_ASSERTIONS
  // the window starts empty after the last pixel of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item_i.last |=> (win_q == '0))
    else $error("window not cleared at frame end");
`endif

endmodule

@@ sv/binary_morphology_3x3.sv @@
// top level of the streaming 3x3 binary dilation and erosion block
//
// channel | dir | handshake                     | payload
// in      | in  | in_valid_i / in_ready_o       | opcode_i, pixel_value_i
// out     | out | out_valid_o / out_ready_i     | out_foreground_o, end_of_frame_o
// config  | in  | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// one pixel transfer per clock while in_ready_o is high; an item passes the read stage
// register, then the output register; output lags input by frame_width+1 transfers
// the line store is read at the transfer; a separate write port writes it as the item
// leaves the read stage, and a same-column rewrite is forwarded to the following read
// after reset a clear sweep zeroes all MAX_WIDTH line store entries with in_ready_o low
// an output stall holds one item in the read stage and one in the output register
module binary_morphology_3x3 #(
  parameter int unsigned MAX_WIDTH  = bmorph_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bmorph_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmorph_pkg::APB_AW-1:0]     paddr,
  input  logic [bmorph_pkg::APB_DW-1:0]     pwdata,
  output logic [bmorph_pkg::APB_DW-1:0]     prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [bmorph_pkg::PIX_W-1:0]      pixel_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_foreground_o,
  output logic                              end_of_frame_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [bmorph_pkg::FW_W-1:0]   frame_width_q, frame_width_d;
  logic [bmorph_pkg::FH_W-1:0]   frame_height_q, frame_height_d;
  logic                          morph_mode_q, morph_mode_d;
  logic [bmorph_pkg::MASK_W-1:0] kernel_mask_q, kernel_mask_d;
  bmorph_pkg::reg_idx_e          reg_idx;
  logic                          cfg_wr;
  logic [31:0]                   fw_ext, fh_ext, fw_clamp, fh_clamp;
  logic [CW:0]                   width;
  logic [RW:0]                   height;

  logic                          stage_ready, rd_en, clr_en, s1_valid, wr_en;
  logic [CW-1:0]                 rd_addr, clr_addr, s1_addr;
  logic [bmorph_pkg::LINE_W-1:0] rd_data, wr_data;
  bmorph_pkg::item_t             s1_item;

  // register port decode
  assign pready  = 1'b1;
  assign reg_idx = bmorph_pkg::reg_idx_e'(paddr[bmorph_pkg::APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    morph_mode_d   = morph_mode_q;
    kernel_mask_d  = kernel_mask_q;
    if (cfg_wr) begin
      case (reg_idx)
        bmorph_pkg::REG_FRAME_WIDTH:  frame_width_d  = pwdata[bmorph_pkg::FW_W-1:0];
        bmorph_pkg::REG_FRAME_HEIGHT: frame_height_d = pwdata[bmorph_pkg::FH_W-1:0];
        bmorph_pkg::REG_MORPH_MODE:   morph_mode_d   = pwdata[0];
        bmorph_pkg::REG_KERNEL_MASK:  kernel_mask_d  = pwdata[bmorph_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= bmorph_pkg::FW_RST;
      frame_height_q <= bmorph_pkg::FH_RST;
      morph_mode_q   <= bmorph_pkg::MODE_DILATE;
      kernel_mask_q  <= bmorph_pkg::MASK_RST;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      morph_mode_q   <= morph_mode_d;
      kernel_mask_q  <= kernel_mask_d;
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      bmorph_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
      bmorph_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
      bmorph_pkg::REG_MORPH_MODE:   prdata = 32'(morph_mode_q);
      bmorph_pkg::REG_KERNEL_MASK:  prdata = 32'(kernel_mask_q);
      default:                      prdata = '0;
    endcase
  end

  // frame size limited to the supported range
  assign fw_ext   = 32'(frame_width_q);
  assign fh_ext   = 32'(frame_height_q);
  assign fw_clamp = (fw_ext < 32'd3) ? 32'd3 :
                    (fw_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : fw_ext;
  assign fh_clamp = (fh_ext < 32'd3) ? 32'd3 :
                    (fh_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : fh_ext;
  assign width    = fw_clamp[CW:0];
  assign height   = fh_clamp[RW:0];

  bmorph_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .pixel_value_i (pixel_value_i),
    .width_i       (width),
    .height_i      (height),
    .stage_ready_i (stage_ready),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .clr_en_o      (clr_en),
    .clr_addr_o    (clr_addr),
    .s1_valid_o    (s1_valid),
    .s1_item_o     (s1_item),
    .s1_addr_o     (s1_addr)
  );

  bmorph_line_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i      (clk_i),
    .clr_en_i   (clr_en),
    .clr_addr_i (clr_addr),
    .wr_en_i    (wr_en),
    .wr_addr_i  (s1_addr),
    .wr_data_i  (wr_data),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data)
  );

  bmorph_win u_win (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s1_valid_i       (s1_valid),
    .item_i           (s1_item),
    .rd_data_i        (rd_data),
    .morph_mode_i     (morph_mode_q),
    .kernel_mask_i    (kernel_mask_q),
    .stage_ready_o    (stage_ready),
    .wr_en_o          (wr_en),
    .wr_data_o        (wr_data),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_foreground_o (out_foreground_o),
    .end_of_frame_o   (end_of_frame_o)
  );

endmodule
